// File: rtl/wwc_pkg.sv
// wwc_pkg: shared codes, widths and types for the weightless classifier
// no dependencies; imported by the interfaces and every module of the block
package wwc_pkg;

  // fixed field widths of the channels
  localparam int OP_W         = 2;
  localparam int ENTRY_W      = 32;
  localparam int LABEL_W      = 2;
  localparam int BEST_CLASS_W = 2;
  localparam int BEST_SCORE_W = 4;

  // entry positions covered by the map registers, five-bit source index each
  localparam int MAP_POS = 32;
  localparam int IDX_W   = 5;
  localparam int MAP_LOW_W  = 60;
  localparam int MAP_MID_W  = 60;
  localparam int MAP_HIGH_W = 40;
  localparam int ACTIVE_W   = 3;
  localparam int ACTIVE_RST = 4;

  // configuration port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TRAIN    = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NOP      = 2'd3
  } wwc_op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAP_LOW  = 2'd0,
    REG_MAP_MID  = 2'd1,
    REG_MAP_HIGH = 2'd2,
    REG_ACTIVE   = 2'd3
  } wwc_reg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_ADDR = 2'd1,
    S_EXEC = 2'd2,
    S_DONE = 2'd3
  } wwc_state_e;

  // per-cycle commands from the sequencer to the banks and the score unit
  typedef struct packed {
    logic clear;  // zero every ram bit
    logic train;  // set the addressed bit of the selected class
    logic scan;   // score the selected class
    logic first;  // first class of a scan, restart the running best
  } wwc_ctrl_t;

endpackage

// File: rtl/wwc_if.sv
// wwc_in_if / wwc_out_if: valid-ready channels for item and result beats
// depends on wwc_pkg for the field widths
interface wwc_in_if;
  import wwc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ENTRY_W-1:0] entry_bits;
  logic [LABEL_W-1:0] class_label;

  modport source (output valid, op, entry_bits, class_label, input ready);
  modport sink   (input valid, op, entry_bits, class_label, output ready);
endinterface

interface wwc_out_if;
  import wwc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BEST_CLASS_W-1:0] best_class;
  logic [BEST_SCORE_W-1:0] best_score;
  logic                    label_error;

  modport source (output valid, best_class, best_score, label_error, input ready);
  modport sink   (input valid, best_class, best_score, label_error, output ready);
endinterface

// File: rtl/wwc_tuple_addr.sv
// wwc_tuple_addr: maps entry bits through the position map into tuple addresses
// depends on wwc_pkg; first position of a tuple is the address msb
module wwc_tuple_addr #(
  parameter int ENTRY_BITS = 32,
  parameter int TUPLE_BITS = 4,
  parameter int NUM_RAMS   = 8
) (
  input  logic [wwc_pkg::ENTRY_W-1:0]    entry_i,
  input  logic [wwc_pkg::MAP_LOW_W-1:0]  map_low_i,
  input  logic [wwc_pkg::MAP_MID_W-1:0]  map_mid_i,
  input  logic [wwc_pkg::MAP_HIGH_W-1:0] map_high_i,
  output logic [NUM_RAMS-1:0][TUPLE_BITS-1:0] addr_o
);
  import wwc_pkg::*;

  localparam int POS_N = NUM_RAMS * TUPLE_BITS;
  localparam int MAP_W = MAP_LOW_W + MAP_MID_W + MAP_HIGH_W;

  logic [MAP_W-1:0] map_all;
  logic [POS_N-1:0] pos_bit;

  assign map_all = {map_high_i, map_mid_i, map_low_i};

  for (genvar p = 0; p < POS_N; p++) begin : g_pos
    if (p < ENTRY_BITS && p < MAP_POS) begin : g_map
      assign pos_bit[p] = entry_i[map_all[IDX_W*p +: IDX_W]];
    end else begin : g_pad
      // padding of a short last tuple
      assign pos_bit[p] = 1'b0;
    end
  end

  for (genvar r = 0; r < NUM_RAMS; r++) begin : g_tup
    for (genvar j = 0; j < TUPLE_BITS; j++) begin : g_bit
      assign addr_o[r][TUPLE_BITS-1-j] = pos_bit[r*TUPLE_BITS+j];
    end
  end

endmodule

// File: rtl/wwc_ram_bank.sv
// wwc_ram_bank: one tuple's one-bit rams, one row per class
// depends on wwc_pkg for the control struct
module wwc_ram_bank #(
  parameter int NUM_CLASSES = 4,
  parameter int TUPLE_BITS  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wwc_pkg::wwc_ctrl_t             ctrl_i,
  input  logic [$clog2(NUM_CLASSES)-1:0] cls_i,
  input  logic [TUPLE_BITS-1:0]          addr_i,
  output logic                           hit_o
);
  import wwc_pkg::*;

  localparam int RAM_SIZE = 1 << TUPLE_BITS;

  logic [NUM_CLASSES-1:0][RAM_SIZE-1:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (ctrl_i.clear) begin
      rows_q <= '0;
    end else if (ctrl_i.train) begin
      rows_q[cls_i][addr_i] <= 1'b1;
    end
  end

  assign hit_o = rows_q[cls_i][addr_i];

endmodule

// File: rtl/wwc_score_unit.sv
// wwc_score_unit: shared hit counter and running best compare, one class per cycle
// depends on wwc_pkg for the control struct
module wwc_score_unit #(
  parameter int NUM_RAMS = 8,
  parameter int CLS_W    = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wwc_pkg::wwc_ctrl_t                ctrl_i,
  input  logic [CLS_W-1:0]                  cls_i,
  input  logic [NUM_RAMS-1:0]               hits_i,
  output logic [CLS_W-1:0]                  best_cls_o,
  output logic [$clog2(NUM_RAMS+1)-1:0]     best_score_o
);
  import wwc_pkg::*;

  localparam int SCORE_W = $clog2(NUM_RAMS + 1);

  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] ref_score;
  logic [CLS_W-1:0]   best_cls_q, best_cls_d;
  logic [SCORE_W-1:0] best_score_q, best_score_d;

  always_comb begin
    score = '0;
    for (int i = 0; i < NUM_RAMS; i++) begin
      score = score + SCORE_W'(hits_i[i]);
    end
  end

  // strictly greater wins, so ties keep the lower class
  always_comb begin
    ref_score    = ctrl_i.first ? '0 : best_score_q;
    best_cls_d   = ctrl_i.first ? '0 : best_cls_q;
    best_score_d = ref_score;
    if (score > ref_score) begin
      best_cls_d   = cls_i;
      best_score_d = score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cls_q   <= '0;
      best_score_q <= '0;
    end else if (ctrl_i.scan) begin
      best_cls_q   <= best_cls_d;
      best_score_q <= best_score_d;
    end
  end

  assign best_cls_o   = best_cls_q;
  assign best_score_o = best_score_q;

endmodule

// File: rtl/wisard_weightless_classifier_unit.sv
// wisard_weightless_classifier_unit: top level, sequencer, config registers, result register
// depends on wwc_pkg, wwc_if, wwc_tuple_addr, wwc_ram_bank, wwc_score_unit
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------
//  req_i   | in  | valid / ready         | op, entry_bits, class_label
//  rsp_o   | out | valid / ready         | best_class, best_score, label_error
//  apb     | in  | psel, penable, pready | paddr, pwdata, pwrite, prdata
//
// an item beat is followed by the address state, then the execute state, once for train,
// clear or no-op and once per active class for classify (the shared score unit counts
// the hits of one class per cycle), then the done state, which loads the result
// register once rsp_o has room for it
// reset clears the rams, config and control registers at once, no clearing pass
// a waiting result on rsp_o stalls the next result load, not the next item beat
module wisard_weightless_classifier_unit #(
  parameter int ENTRY_BITS  = 32,
  parameter int TUPLE_BITS  = 4,
  parameter int NUM_CLASSES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wwc_in_if.sink                         req_i,
  wwc_out_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wwc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wwc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wwc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import wwc_pkg::*;

  localparam int NUM_RAMS = (ENTRY_BITS + TUPLE_BITS - 1) / TUPLE_BITS;
  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int CNT_W    = $clog2(NUM_CLASSES + 1);
  localparam int SCORE_W  = $clog2(NUM_RAMS + 1);

  // configuration registers
  logic [MAP_LOW_W-1:0]  map_low_q;
  logic [MAP_MID_W-1:0]  map_mid_q;
  logic [MAP_HIGH_W-1:0] map_high_q;
  logic [ACTIVE_W-1:0]   active_q;
  logic                  cfg_wr;
  wwc_reg_e              reg_idx;

  // sequencer
  wwc_state_e state_q, state_d;
  wwc_op_e    op_q;
  logic [ENTRY_W-1:0] entry_q;
  logic [LABEL_W-1:0] label_q;
  logic [CLS_W-1:0]   cls_q, cls_d;
  logic [CNT_W-1:0]   ncls;
  logic               last_cls;
  logic               label_err;
  logic               in_beat;
  logic               out_room;
  wwc_ctrl_t          ctrl;
  logic [CLS_W-1:0]   bank_cls;

  // tuple addresses and bank hits
  logic [NUM_RAMS-1:0][TUPLE_BITS-1:0] addr_d, addr_q;
  logic [NUM_RAMS-1:0]                 hits;
  logic [CLS_W-1:0]                    best_cls;
  logic [SCORE_W-1:0]                  best_score;

  // result register
  logic                    out_vld_q, out_vld_d;
  logic [BEST_CLASS_W-1:0] out_class_q, out_class_d;
  logic [BEST_SCORE_W-1:0] out_score_q, out_score_d;
  logic                    out_err_q, out_err_d;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = wwc_reg_e'(paddr[APB_ADDR_W-1 -: REG_IDX_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_low_q  <= '0;
      map_mid_q  <= '0;
      map_high_q <= '0;
      active_q   <= ACTIVE_W'(ACTIVE_RST);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAP_LOW:  map_low_q  <= pwdata[MAP_LOW_W-1:0];
        REG_MAP_MID:  map_mid_q  <= pwdata[MAP_MID_W-1:0];
        REG_MAP_HIGH: map_high_q <= pwdata[MAP_HIGH_W-1:0];
        REG_ACTIVE:   active_q   <= pwdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAP_LOW:  prdata = APB_DATA_W'(map_low_q);
      REG_MAP_MID:  prdata = APB_DATA_W'(map_mid_q);
      REG_MAP_HIGH: prdata = APB_DATA_W'(map_high_q);
      REG_ACTIVE:   prdata = APB_DATA_W'(active_q);
      default:      prdata = '0;
    endcase
  end

  // effective class count: zero counts as one, saturate at the class count
  always_comb begin
    if (active_q == '0) begin
      ncls = CNT_W'(1);
    end else if (int'(active_q) > NUM_CLASSES) begin
      ncls = CNT_W'(NUM_CLASSES);
    end else begin
      ncls = CNT_W'(active_q);
    end
  end

  assign label_err = int'(label_q) >= int'(ncls);
  assign last_cls  = (CNT_W'(cls_q) + CNT_W'(1)) == ncls;

  // ---------------------------------------------------------------- sequencer
  assign req_i.ready = (state_q == S_IDLE);
  assign in_beat     = req_i.valid && req_i.ready;
  assign out_room    = !out_vld_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_ADDR;
      end
      S_ADDR: state_d = S_EXEC;
      S_EXEC: begin
        // classify stays here once per active class
        if (op_q != OP_CLASSIFY || last_cls) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_room) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl  = '0;
    cls_d = '0;
    case (state_q)
      S_EXEC: begin
        case (op_q)
          OP_TRAIN:    ctrl.train = !label_err;
          OP_CLASSIFY: begin
            ctrl.scan  = 1'b1;
            ctrl.first = (cls_q == '0);
            cls_d      = last_cls ? cls_q : cls_q + CLS_W'(1);
          end
          OP_CLEAR:    ctrl.clear = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign bank_cls = (op_q == OP_CLASSIFY) ? cls_q : CLS_W'(label_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cls_q   <= '0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
    end
  end

  // item payload, captured on the input beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q    <= wwc_op_e'(req_i.op);
      entry_q <= req_i.entry_bits;
      label_q <= req_i.class_label;
    end
    if (state_q == S_ADDR) begin
      addr_q <= addr_d;
    end
  end

  // ---------------------------------------------------------------- datapath
  wwc_tuple_addr #(
    .ENTRY_BITS (ENTRY_BITS),
    .TUPLE_BITS (TUPLE_BITS),
    .NUM_RAMS   (NUM_RAMS)
  ) u_tuple_addr (
    .entry_i    (entry_q),
    .map_low_i  (map_low_q),
    .map_mid_i  (map_mid_q),
    .map_high_i (map_high_q),
    .addr_o     (addr_d)
  );

  for (genvar r = 0; r < NUM_RAMS; r++) begin : g_bank
    wwc_ram_bank #(
      .NUM_CLASSES (NUM_CLASSES),
      .TUPLE_BITS  (TUPLE_BITS)
    ) u_bank (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .cls_i  (bank_cls),
      .addr_i (addr_q[r]),
      .hit_o  (hits[r])
    );
  end

  wwc_score_unit #(
    .NUM_RAMS (NUM_RAMS),
    .CLS_W    (CLS_W)
  ) u_score (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cls_i        (cls_q),
    .hits_i       (hits),
    .best_cls_o   (best_cls),
    .best_score_o (best_score)
  );

  // ---------------------------------------------------------------- result register
  always_comb begin
    out_class_d = '0;
    out_score_d = '0;
    out_err_d   = 1'b0;
    case (op_q)
      OP_CLASSIFY: begin
        out_class_d = BEST_CLASS_W'(best_cls);
        out_score_d = BEST_SCORE_W'(best_score);
      end
      OP_TRAIN: out_err_d = label_err;
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (rsp_o.ready) out_vld_d = 1'b0;
    if (state_q == S_DONE && out_room) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_room) begin
      out_class_q <= out_class_d;
      out_score_q <= out_score_d;
      out_err_q   <= out_err_d;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.best_class  = out_class_q;
  assign rsp_o.best_score  = out_score_q;
  assign rsp_o.label_error = out_err_q;

endmodule
